// ----- design/mcc_pkg.sv -----
// Shared types and constants for the MESI cache controller.
package mcc_pkg;

    typedef enum logic [1:0] {
        ST_I = 2'd0,
        ST_S = 2'd1,
        ST_E = 2'd2,
        ST_M = 2'd3
    } t_mesi;

    localparam logic [2:0] REQ_CPU_RD  = 3'd0;
    localparam logic [2:0] REQ_CPU_WR  = 3'd1;
    localparam logic [2:0] REQ_SNP_RD  = 3'd2;
    localparam logic [2:0] REQ_SNP_WR  = 3'd3;
    localparam logic [2:0] REQ_SET_ST  = 3'd4;

    localparam logic [1:0] BUS_NONE  = 2'd0;
    localparam logic [1:0] BUS_RD    = 2'd1;
    localparam logic [1:0] BUS_RDX   = 2'd2;

    localparam logic [9:0] MEM_CYCLES = 10'd100;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] address;
        logic [30:0] cycle;
        logic [9:0]  pending_stalls;
        logic        first_try;
        logic        bus_busy;
        logic [1:0]  other_state;
        logic [1:0]  forced_state;
    } t_req;

    typedef struct packed {
        logic        hit;
        logic [1:0]  snoop_state;
        logic [9:0]  stall_add;
        logic [9:0]  bus_hold;
        logic [1:0]  bus_request;
        logic        invalidate_request;
        logic [31:0] miss_total;
        logic [31:0] eviction_total;
        logic [31:0] writeback_total;
        logic [31:0] traffic_bytes;
    } t_rsp;

    // per-way compare flags from the shared compare unit
    typedef struct packed {
        logic valid;
        logic match;
        logic less;
    } t_cmp;

endpackage

// ----- design/mcc_ifs.sv -----
// Request and response channel interfaces.
interface mcc_req_if;
    import mcc_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mcc_rsp_if;
    import mcc_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- design/mcc_mem.sv -----
// Single-port-write, registered-read line store.
module mcc_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 55
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- design/mcc_way_cmp.sv -----
// Shared tag and LRU stamp comparator, used once per way during a scan.
module mcc_way_cmp #(
    parameter int TAG_W = 21
) (
    input  logic [1:0]       i_state,
    input  logic [TAG_W-1:0] i_tag,
    input  logic [31:0]      i_stamp,
    input  logic [TAG_W-1:0] i_ref_tag,
    input  logic [31:0]      i_min,
    input  logic             i_first,
    output mcc_pkg::t_cmp    o_res
);
    import mcc_pkg::*;

    always_comb begin
        o_res.valid = (i_state != ST_I);
        o_res.match = (i_state != ST_I) && (i_tag == i_ref_tag);
        // way 0 always seeds the LRU candidate
        o_res.less  = (i_stamp < i_min) || i_first;
    end
endmodule

// ----- design/mesi_cache_controller.sv -----
// MESI cache tag/state store with LRU replacement: top level and sequencer.
//
// Requests arrive on i_req (valid/ready); each produces exactly one response
// on o_rsp. A request is taken only when the sequencer is idle. It reads the
// ways of the addressed set one at a time from the line store (each way is
// read, then compared in the shared comparator), then resolves hit/miss/victim
// and writes at most one line back. A new request cannot be taken until the
// previous one has left the resolve step.
// The response sits in an output register; a new request may be taken while
// it waits, but the resolve step holds until the previous response has been
// transferred. After reset, a clear pass writes zero to every line of the
// store before the first request is taken. Counters reset to zero and wrap.
module mesi_cache_controller #(
    parameter int INDEX_BITS  = 6,
    parameter int WAYS        = 4,
    parameter int OFFSET_BITS = 5
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mcc_req_if.sink   i_req,
    mcc_rsp_if.source o_rsp
);
    import mcc_pkg::*;

    localparam int NSETS  = 1 << INDEX_BITS;
    localparam int NLINES = NSETS * WAYS;
    localparam int TAG_W  = 32 - OFFSET_BITS - INDEX_BITS;
    localparam int IDXW   = (NLINES > 1) ? $clog2(NLINES) : 1;
    localparam int WIW    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SW     = (INDEX_BITS > 0) ? INDEX_BITS : 1;
    localparam int DW     = 2 + TAG_W + 32;
    localparam logic [31:0] BLOCK_BYTES = 32'(1 << OFFSET_BITS);
    localparam logic [9:0]  SHARED_FILL = 10'((1 << OFFSET_BITS) / 2);

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_CMP, S_EXEC} t_seq;

    t_seq              r_seq;
    logic [IDXW-1:0]   r_clr;
    logic [WIW-1:0]    r_way;
    t_req              r_req;
    logic [SW-1:0]     r_set;
    logic [TAG_W-1:0]  r_tag;
    logic              r_hit_found;
    logic [WIW-1:0]    r_hit_way;
    logic [1:0]        r_hit_state;
    logic [31:0]       r_hit_stamp;
    logic              r_inv_found;
    logic [WIW-1:0]    r_vic_way;
    logic [1:0]        r_vic_state;
    logic [TAG_W-1:0]  r_vic_tag;
    logic [31:0]       r_min;
    logic [31:0]       r_miss;
    logic [31:0]       r_evict;
    logic [31:0]       r_wb;
    logic [31:0]       r_traffic;
    logic              r_ovalid;
    t_rsp              r_rsp;

    logic              mem_we;
    logic [IDXW-1:0]   mem_waddr;
    logic [DW-1:0]     mem_wdata;
    logic [IDXW-1:0]   mem_raddr;
    logic [DW-1:0]     mem_rdata;
    logic [1:0]        rd_state;
    logic [TAG_W-1:0]  rd_tag;
    logic [31:0]       rd_stamp;
    t_cmp              cmp;
    logic              go;

    // resolve-step results
    logic              n_we;
    logic [WIW-1:0]    n_way;
    logic [1:0]        n_state;
    logic [TAG_W-1:0]  n_tag;
    logic [31:0]       n_stamp;
    logic [31:0]       n_miss;
    logic [31:0]       n_evict;
    logic [31:0]       n_wb;
    logic [31:0]       n_traffic;
    t_rsp              n_rsp;

    assign {rd_state, rd_tag, rd_stamp} = mem_rdata;

    mcc_mem #(.DEPTH(NLINES), .AW(IDXW), .DW(DW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    mcc_way_cmp #(.TAG_W(TAG_W)) u_cmp (
        .i_state   (rd_state),
        .i_tag     (rd_tag),
        .i_stamp   (rd_stamp),
        .i_ref_tag (r_tag),
        .i_min     (r_min),
        .i_first   (r_way == '0),
        .o_res     (cmp)
    );

    assign go          = (r_seq == S_EXEC) && (!r_ovalid || o_rsp.ready);
    assign i_req.ready = (r_seq == S_IDLE);
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.data  = r_rsp;
    assign mem_raddr   = IDXW'(32'(r_set) * WAYS + 32'(r_way));

    always_comb begin
        if (r_seq == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr;
            mem_wdata = '0;
        end else begin
            mem_we    = go && n_we;
            mem_waddr = IDXW'(32'(r_set) * WAYS + 32'(n_way));
            mem_wdata = {n_state, n_tag, n_stamp};
        end
    end

    always_comb begin
        logic [31:0] base_stamp;
        logic [31:0] old_addr;
        logic [9:0]  stall;
        logic [9:0]  hold;
        base_stamp = 32'(r_req.cycle) + 32'(r_req.pending_stalls);
        old_addr   = (32'(r_vic_tag) << (OFFSET_BITS + INDEX_BITS))
                   | (32'(r_set) << OFFSET_BITS);
        stall      = '0;
        hold       = '0;
        n_we       = 1'b0;
        n_way      = r_hit_way;
        n_state    = r_hit_state;
        n_tag      = r_tag;
        n_stamp    = 32'(r_req.cycle);
        n_miss     = r_miss;
        n_evict    = r_evict;
        n_wb       = r_wb;
        n_traffic  = r_traffic;
        n_rsp      = '0;
        case (r_req.req_type)
            REQ_CPU_RD, REQ_CPU_WR: begin
                if (r_hit_found) begin
                    n_we = 1'b1;
                    if (r_req.req_type == REQ_CPU_RD || r_hit_state == ST_M) begin
                        n_rsp.hit = 1'b1;
                    end else if (r_hit_state == ST_E) begin
                        n_state   = ST_M;
                        n_rsp.hit = 1'b1;
                    end else if (!r_req.bus_busy) begin
                        n_state                  = ST_M;
                        n_rsp.invalidate_request = 1'b1;
                        n_rsp.hit                = 1'b1;
                    end
                end else begin
                    if (r_req.first_try) begin
                        n_miss = r_miss + 32'd1;
                    end
                    if (!r_req.bus_busy) begin
                        n_we  = 1'b1;
                        n_way = r_vic_way;
                        if (r_vic_state != ST_I) begin
                            n_evict = r_evict + 32'd1;
                        end
                        if (r_vic_state == ST_M) begin
                            // dirty victim: write back; a read fills it as E
                            n_wb      = r_wb + 32'd1;
                            n_traffic = r_traffic + BLOCK_BYTES;
                            stall     = MEM_CYCLES;
                            hold      = MEM_CYCLES;
                            if (r_req.req_type == REQ_CPU_WR) begin
                                n_state = ST_I;
                                n_tag   = old_addr[TAG_W-1:0];
                                n_stamp = '0;
                            end else begin
                                n_state = ST_E;
                                n_stamp = base_stamp + 32'(MEM_CYCLES);
                            end
                        end else if (r_req.req_type == REQ_CPU_RD) begin
                            n_rsp.bus_request = BUS_RD;
                            n_traffic         = r_traffic + BLOCK_BYTES;
                            if (r_req.other_state == ST_I) begin
                                stall   = MEM_CYCLES;
                                n_state = ST_E;
                            end else begin
                                stall   = SHARED_FILL;
                                n_state = ST_S;
                            end
                            hold    = stall;
                            n_stamp = base_stamp + 32'(stall);
                            if (r_req.other_state == ST_M) begin
                                n_wb  = r_wb + 32'd1;
                                stall = stall + MEM_CYCLES;
                                hold  = hold + MEM_CYCLES;
                            end
                        end else begin
                            n_rsp.bus_request        = BUS_RDX;
                            n_rsp.invalidate_request = 1'b1;
                            if (r_req.other_state == ST_M) begin
                                n_wb  = r_wb + 32'd1;
                                stall = MEM_CYCLES;
                            end
                            n_traffic = r_traffic + BLOCK_BYTES;
                            stall     = stall + MEM_CYCLES;
                            hold      = MEM_CYCLES;
                            n_state   = ST_E;
                            n_stamp   = base_stamp + 32'(stall);
                        end
                    end
                end
            end
            REQ_SNP_RD, REQ_SNP_WR: begin
                if (r_hit_found) begin
                    n_rsp.snoop_state = r_hit_state;
                    // state change only; the line keeps its stamp
                    n_stamp           = r_hit_stamp;
                    if (r_req.req_type == REQ_SNP_WR) begin
                        if (r_hit_state == ST_M) begin
                            n_we    = 1'b1;
                            n_state = ST_I;
                        end
                    end else if (r_hit_state == ST_M || r_hit_state == ST_E) begin
                        n_we    = 1'b1;
                        n_state = ST_S;
                    end
                end
            end
            REQ_SET_ST: begin
                n_we    = r_hit_found;
                n_state = r_req.forced_state;
                n_stamp = r_hit_stamp;
            end
            default: begin
                n_we = 1'b0;
            end
        endcase
        n_rsp.stall_add       = stall;
        n_rsp.bus_hold        = hold;
        n_rsp.miss_total      = n_miss;
        n_rsp.eviction_total  = n_evict;
        n_rsp.writeback_total = n_wb;
        n_rsp.traffic_bytes   = n_traffic;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq     <= S_CLEAR;
            r_clr     <= '0;
            r_way     <= '0;
            r_miss    <= '0;
            r_evict   <= '0;
            r_wb      <= '0;
            r_traffic <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            if (go) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_seq)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == IDXW'(NLINES - 1)) begin
                        r_seq <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_req       <= i_req.data;
                        r_set       <= SW'((i_req.data.address >> OFFSET_BITS)
                                           & 32'(NSETS - 1));
                        r_tag       <= TAG_W'(i_req.data.address
                                              >> (OFFSET_BITS + INDEX_BITS));
                        r_way       <= '0;
                        r_hit_found <= 1'b0;
                        r_inv_found <= 1'b0;
                        r_vic_way   <= '0;
                        r_min       <= '1;
                        r_seq       <= S_READ;
                    end
                end
                S_READ: begin
                    r_seq <= S_CMP;
                end
                S_CMP: begin
                    if (!r_hit_found && cmp.match) begin
                        r_hit_found <= 1'b1;
                        r_hit_way   <= r_way;
                        r_hit_state <= rd_state;
                        r_hit_stamp <= rd_stamp;
                    end
                    if (!r_inv_found) begin
                        if (!cmp.valid) begin
                            r_inv_found <= 1'b1;
                            r_vic_way   <= r_way;
                            r_vic_state <= rd_state;
                            r_vic_tag   <= rd_tag;
                        end else if (cmp.less) begin
                            r_min       <= rd_stamp;
                            r_vic_way   <= r_way;
                            r_vic_state <= rd_state;
                            r_vic_tag   <= rd_tag;
                        end
                    end
                    if (r_way == WIW'(WAYS - 1)) begin
                        r_seq <= S_EXEC;
                    end else begin
                        r_way <= r_way + 1'b1;
                        r_seq <= S_READ;
                    end
                end
                S_EXEC: begin
                    if (go) begin
                        r_miss    <= n_miss;
                        r_evict   <= n_evict;
                        r_wb      <= n_wb;
                        r_traffic <= n_traffic;
                        r_rsp     <= n_rsp;
                        r_seq     <= S_IDLE;
                    end
                end
                default: begin
                    r_seq <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- bench/tb_top.sv -----
// Testbench for mesi_cache_controller: directed table plus random traffic, checked by a predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import mcc_pkg::*;

    localparam int INDEX_BITS  = 6;
    localparam int WAYS        = 4;
    localparam int OFFSET_BITS = 5;
    localparam int NSETS       = 1 << INDEX_BITS;
    localparam int TAG_W       = 32 - OFFSET_BITS - INDEX_BITS;
    localparam logic [31:0] BLOCK_BYTES = 32'(1 << OFFSET_BITS);
    localparam int N_RANDOM    = 600;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    mcc_req_if req_ch();
    mcc_rsp_if rsp_ch();

    mesi_cache_controller #(
        .INDEX_BITS(INDEX_BITS), .WAYS(WAYS), .OFFSET_BITS(OFFSET_BITS)
    ) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_ch.sink), .o_rsp(rsp_ch.source)
    );

    always #10 i_clk = ~i_clk;

    // predictor copy of the cache
    t_mesi            pm_state [NSETS*WAYS];
    logic [TAG_W-1:0] pm_tag   [NSETS*WAYS];
    logic [31:0]      pm_stamp [NSETS*WAYS];
    logic [31:0]      pm_miss, pm_evict, pm_wb, pm_traffic;

    t_rsp expected_rsp [$];
    int   n_errors = 0;

    // directed rows: request plus optional typed-in result
    typedef struct {
        t_req req;
        bit   has_exp;
        t_rsp exp;
    } t_row;
    t_row dir_rows [$];

    function automatic t_rsp predict_access(t_req r);
        t_rsp o;
        int unsigned set_idx, base, hit_way, vw, v;
        logic [TAG_W-1:0] tg;
        logic [31:0] stall, hold, old;
        logic [31:0] min_stamp;
        bit done;
        o = '0;
        set_idx = (r.address >> OFFSET_BITS) & (NSETS - 1);
        tg = TAG_W'(r.address >> (OFFSET_BITS + INDEX_BITS));
        base = set_idx * WAYS;
        hit_way = WAYS;
        stall = 0;
        hold = 0;
        for (int w = WAYS - 1; w >= 0; w--)
            if (pm_state[base+w] != ST_I && pm_tag[base+w] == tg) hit_way = w;
        case (r.req_type)
            REQ_CPU_RD, REQ_CPU_WR: begin
                if (hit_way < WAYS) begin
                    v = base + hit_way;
                    pm_stamp[v] = {1'b0, r.cycle};
                    if (r.req_type == REQ_CPU_RD || pm_state[v] == ST_M) begin
                        o.hit = 1;
                    end else if (pm_state[v] == ST_E) begin
                        pm_state[v] = ST_M;
                        o.hit = 1;
                    end else if (!r.bus_busy) begin
                        pm_state[v] = ST_M;
                        o.invalidate_request = 1;
                        o.hit = 1;
                    end
                end else begin
                    if (r.first_try) pm_miss++;
                    if (!r.bus_busy) begin
                        vw = WAYS;
                        min_stamp = '1;
                        for (int w = 0; w < WAYS; w++) begin
                            if (vw == WAYS && pm_state[base+w] == ST_I) vw = w;
                        end
                        if (vw == WAYS) begin
                            vw = 0;
                            for (int w = 0; w < WAYS; w++)
                                if (pm_stamp[base+w] < min_stamp) begin
                                    min_stamp = pm_stamp[base+w];
                                    vw = w;
                                end
                        end
                        v = base + vw;
                        done = 0;
                        if (pm_state[v] != ST_I) begin
                            pm_evict++;
                            if (pm_state[v] == ST_M) begin
                                pm_wb++;
                                pm_traffic += BLOCK_BYTES;
                                stall = MEM_CYCLES;
                                hold = MEM_CYCLES;
                                if (r.req_type == REQ_CPU_WR) begin
                                    old = (32'(pm_tag[v]) << (OFFSET_BITS + INDEX_BITS))
                                        | (set_idx << OFFSET_BITS);
                                    pm_state[v] = ST_I;
                                    pm_tag[v] = old[TAG_W-1:0];
                                    pm_stamp[v] = 0;
                                end else begin
                                    pm_state[v] = ST_E;
                                    pm_tag[v] = tg;
                                    pm_stamp[v] = r.cycle + r.pending_stalls + stall;
                                end
                                done = 1;
                            end
                        end
                        if (!done && r.req_type == REQ_CPU_RD) begin
                            o.bus_request = BUS_RD;
                            pm_traffic += BLOCK_BYTES;
                            if (r.other_state == ST_I) begin
                                stall = MEM_CYCLES;
                                hold = MEM_CYCLES;
                                pm_state[v] = ST_E;
                            end else begin
                                stall = 2 * (BLOCK_BYTES >> 2);
                                hold = stall;
                                pm_state[v] = ST_S;
                            end
                            pm_tag[v] = tg;
                            pm_stamp[v] = r.cycle + r.pending_stalls + stall;
                            if (r.other_state == ST_M) begin
                                pm_wb++;
                                stall += MEM_CYCLES;
                                hold += MEM_CYCLES;
                            end
                        end else if (!done) begin
                            o.bus_request = BUS_RDX;
                            o.invalidate_request = 1;
                            if (r.other_state == ST_M) begin
                                pm_wb++;
                                stall += MEM_CYCLES;
                            end
                            pm_traffic += BLOCK_BYTES;
                            stall += MEM_CYCLES;
                            hold = MEM_CYCLES;
                            pm_state[v] = ST_E;
                            pm_tag[v] = tg;
                            pm_stamp[v] = r.cycle + r.pending_stalls + stall;
                        end
                    end
                end
            end
            REQ_SNP_RD, REQ_SNP_WR: begin
                if (hit_way < WAYS) begin
                    v = base + hit_way;
                    o.snoop_state = pm_state[v];
                    if (r.req_type == REQ_SNP_WR) begin
                        if (pm_state[v] == ST_M) pm_state[v] = ST_I;
                    end else if (pm_state[v] == ST_M || pm_state[v] == ST_E) begin
                        pm_state[v] = ST_S;
                    end
                end
            end
            REQ_SET_ST: begin
                if (hit_way < WAYS) pm_state[base+hit_way] = t_mesi'(r.forced_state);
            end
            default: ;
        endcase
        o.stall_add = stall[9:0];
        o.bus_hold = hold[9:0];
        o.miss_total = pm_miss;
        o.eviction_total = pm_evict;
        o.writeback_total = pm_wb;
        o.traffic_bytes = pm_traffic;
        return o;
    endfunction

    function automatic t_req make_req(logic [2:0] kind, logic [31:0] addr, logic busy,
                                      logic [1:0] other, logic [1:0] forced);
        t_req r;
        r.req_type = kind;
        r.address = addr;
        r.cycle = 31'($urandom);
        r.pending_stalls = 10'($urandom);
        r.first_try = 1'($urandom);
        r.bus_busy = busy;
        r.other_state = other;
        r.forced_state = forced;
        return r;
    endfunction

    task automatic add_row(t_req r, bit has_exp = 0, t_rsp e = '0);
        t_row row;
        row.req = r;
        row.has_exp = has_exp;
        row.exp = e;
        dir_rows.push_back(row);
    endtask

    // valid stays high across back-to-back transfers; it drops only for a gap
    task automatic send_req(t_req r);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data <= r;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    // response side: random stalls, compare against oldest expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_rsp.size() == 0) begin
                    $error("response with nothing expected");
                    n_errors++;
                end else begin
                    t_rsp e;
                    t_rsp a;
                    e = expected_rsp.pop_front();
                    a = rsp_ch.data;
                    if (a.hit !== e.hit) begin
                        $error("hit exp %0d got %0d", e.hit, a.hit); n_errors++;
                    end
                    if (a.snoop_state !== e.snoop_state) begin
                        $error("snoop_state exp %0d got %0d", e.snoop_state, a.snoop_state);
                        n_errors++;
                    end
                    if (a.stall_add !== e.stall_add) begin
                        $error("stall_add exp %0d got %0d", e.stall_add, a.stall_add);
                        n_errors++;
                    end
                    if (a.bus_hold !== e.bus_hold) begin
                        $error("bus_hold exp %0d got %0d", e.bus_hold, a.bus_hold);
                        n_errors++;
                    end
                    if (a.bus_request !== e.bus_request) begin
                        $error("bus_request exp %0d got %0d", e.bus_request, a.bus_request);
                        n_errors++;
                    end
                    if (a.invalidate_request !== e.invalidate_request) begin
                        $error("invalidate_request exp %0d got %0d",
                               e.invalidate_request, a.invalidate_request);
                        n_errors++;
                    end
                    if (a.miss_total !== e.miss_total) begin
                        $error("miss_total exp %0d got %0d", e.miss_total, a.miss_total);
                        n_errors++;
                    end
                    if (a.eviction_total !== e.eviction_total) begin
                        $error("eviction_total exp %0d got %0d",
                               e.eviction_total, a.eviction_total);
                        n_errors++;
                    end
                    if (a.writeback_total !== e.writeback_total) begin
                        $error("writeback_total exp %0d got %0d",
                               e.writeback_total, a.writeback_total);
                        n_errors++;
                    end
                    if (a.traffic_bytes !== e.traffic_bytes) begin
                        $error("traffic_bytes exp %0d got %0d", e.traffic_bytes, a.traffic_bytes);
                        n_errors++;
                    end
                end
            end
            // long stalls occasionally, otherwise mostly ready
            if ($urandom_range(0, 49) == 0) rsp_ch.ready <= 1'b0;
            else if ($urandom_range(0, 9) < 7) rsp_ch.ready <= 1'b1;
            else rsp_ch.ready <= (($urandom_range(0, 3) == 0) ? 1'b0 : rsp_ch.ready);
        end
    end

    // queue expectation when a request transfers
    always @(posedge i_clk) begin
        if (i_rst_n && req_ch.valid && req_ch.ready) begin
            t_rsp p;
            p = predict_access(req_ch.data);
            if (dir_rows.size() > 0 && dir_rows[0].req == req_ch.data) begin
                if (dir_rows[0].has_exp) begin
                    if (dir_rows[0].exp != p) begin
                        $error("directed row disagrees with predictor");
                        n_errors++;
                    end
                    p = dir_rows[0].exp;
                end
                void'(dir_rows.pop_front());
            end
            expected_rsp.push_back(p);
        end
    end

    initial begin
        t_rsp e;
        t_req r;
        logic [31:0] hot [16];
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        for (int i = 0; i < NSETS*WAYS; i++) begin
            pm_state[i] = ST_I;
            pm_tag[i] = '0;
            pm_stamp[i] = '0;
        end
        pm_miss = 0; pm_evict = 0; pm_wb = 0; pm_traffic = 0;

        // directed table: snoop, set and unused kinds on empty cache, fills, upgrades, evictions
        e = '0;
        add_row(make_req(REQ_SNP_RD, 32'h0, 0, ST_I, ST_I), 1, e);
        add_row(make_req(REQ_SET_ST, 32'hFFFF_FFFF, 0, ST_I, ST_M), 1, e);
        add_row(make_req(3'd5, 32'h1234, 0, ST_I, ST_I), 1, e);
        add_row(make_req(3'd7, 32'hFFFF_FFFF, 1, ST_M, ST_M), 1, e);
        add_row(make_req(REQ_CPU_RD, 32'h0000_0000, 0, ST_I, ST_I));
        add_row(make_req(REQ_CPU_RD, 32'hFFFF_FFE0, 0, ST_S, ST_I));
        add_row(make_req(REQ_CPU_RD, 32'h0000_0800, 0, ST_M, ST_I));
        add_row(make_req(REQ_CPU_RD, 32'h0000_1000, 0, ST_E, ST_I));
        add_row(make_req(REQ_CPU_WR, 32'h0000_0000, 0, ST_I, ST_I));   // E -> M
        add_row(make_req(REQ_CPU_WR, 32'h0000_0800, 1, ST_I, ST_I));   // S busy
        add_row(make_req(REQ_CPU_WR, 32'h0000_0800, 0, ST_I, ST_I));   // S upgrade
        add_row(make_req(REQ_CPU_WR, 32'h0000_1800, 1, ST_I, ST_I));   // miss, busy
        add_row(make_req(REQ_CPU_WR, 32'h0000_1800, 0, ST_M, ST_I));   // write fill
        add_row(make_req(REQ_CPU_RD, 32'h0000_2000, 0, ST_I, ST_I));   // evict, read
        add_row(make_req(REQ_CPU_WR, 32'h0000_2800, 0, ST_I, ST_I));   // evict, write
        add_row(make_req(REQ_SNP_RD, 32'h0000_1000, 0, ST_I, ST_I));
        add_row(make_req(REQ_SNP_WR, 32'h0000_2000, 0, ST_I, ST_I));
        add_row(make_req(REQ_SET_ST, 32'h0000_1000, 0, ST_I, ST_M));
        add_row(make_req(REQ_SNP_WR, 32'h0000_1000, 0, ST_I, ST_I));
        add_row(make_req(REQ_SET_ST, 32'hFFFF_FFE0, 0, ST_I, ST_I));
        add_row(make_req(REQ_SNP_RD, 32'hFFFF_FFFF, 0, ST_I, ST_I));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // walk a snapshot; the monitor pops rows as they transfer
        begin
            t_req tbl [$];
            foreach (dir_rows[i]) tbl.push_back(dir_rows[i].req);
            foreach (tbl[i]) send_req(tbl[i]);
        end

        // random: a small pool of hot lines in few sets to force hits and evictions
        foreach (hot[i])
            hot[i] = {21'($urandom_range(0, 5)), 6'($urandom_range(0, 2)), 5'($urandom)};
        for (int n = 0; n < N_RANDOM; n++) begin
            logic [31:0] a;
            if ($urandom_range(0, 9) < 8) a = hot[$urandom_range(0, 15)] ^ 32'($urandom_range(0, 31));
            else a = $urandom;
            r = make_req(3'($urandom_range(0, 9) < 8 ? $urandom_range(0, 4)
                                                     : $urandom_range(0, 7)),
                         a, $urandom_range(0, 3) == 0, 2'($urandom), 2'($urandom));
            if ($urandom_range(0, 20) == 0) r.cycle = '1;
            if ($urandom_range(0, 20) == 0) r.pending_stalls = '1;
            send_req(r);
        end
        req_ch.valid <= 1'b0;
        while (expected_rsp.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
